[src/obb_fat_pkg.sv]
// ---------------------------------------------------------------------------
// obb_fat_pkg
// Shared widths, codes and types for the oriented box face-axis overlap test.
// ---------------------------------------------------------------------------
package obb_fat_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int SLOT_WIDTH  = 3;
	localparam int AXIS_WIDTH  = 3;

	// Center difference, its products and dot sums, and the unsigned bound sum.
	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int PROD_W = 2 * COORD_WIDTH + 1;
	localparam int DOT_W  = 2 * COORD_WIDTH + 3;
	localparam int SUM_W  = 2 * COORD_WIDTH + 4;

	localparam logic [SLOT_WIDTH-1:0] SLOT_CENTER_A = 3'd0;
	localparam logic [SLOT_WIDTH-1:0] SLOT_CENTER_B = 3'd4;

	localparam logic [AXIS_WIDTH-1:0] AXIS_LAST_A = 3'd2;
	localparam logic [AXIS_WIDTH-1:0] AXIS_LAST   = 3'd5;
	localparam logic [AXIS_WIDTH-1:0] AXIS_NONE   = 3'd6;

	// Term 0 is the center difference, 1..3 the half axes of A, 4..6 those of B.
	localparam logic [2:0] TERM_DIFF   = 3'd0;
	localparam logic [2:0] TERM_FIRST  = 3'd1;
	localparam logic [2:0] TERM_LAST_A = 3'd3;
	localparam logic [2:0] TERM_LAST   = 3'd6;

	localparam logic [1:0] COMP_FIRST = 2'd0;
	localparam logic [1:0] COMP_LAST  = 2'd2;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ISSUE,
		ST_DRAIN,
		ST_CMP,
		ST_DONE
	} state_t;

endpackage

[src/obb_fat_if.sv]
// ---------------------------------------------------------------------------
// obb_fat_if
// Valid/ready channels for vector loads and for overlap results.
// ---------------------------------------------------------------------------
interface obb_fat_in_if;
	import obb_fat_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [SLOT_WIDTH-1:0] vector_slot;
	coord_t                coord_x;
	coord_t                coord_y;
	coord_t                coord_z;
	logic                  run_test;

	modport source (output valid, vector_slot, coord_x, coord_y, coord_z, run_test,
		input ready);
	modport sink (input valid, vector_slot, coord_x, coord_y, coord_z, run_test,
		output ready);
endinterface

interface obb_fat_out_if;
	import obb_fat_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  overlap;
	logic [AXIS_WIDTH-1:0] separating_axis;

	modport source (output valid, overlap, separating_axis, input ready);
	modport sink (input valid, overlap, separating_axis, output ready);
endinterface

[src/obb_face_axis_overlap_test.sv]
// ---------------------------------------------------------------------------
// obb_face_axis_overlap_test
// Separating axis test of two oriented boxes over their six face axes.
// ---------------------------------------------------------------------------
// Each request on the load channel writes one vector (a center or a half axis
// of box A or B) into an eight-slot store. A request with run_test set
// writes its vector and then starts the test; load.ready stays low until
// the test has delivered its result into the output register.
// The test runs every product of every dot product through one shared
// multiplier, one product per cycle: per axis 21 products, then a drain of
// the accumulate and bound stages and a compare. After a setup step, the
// test examines the axes up to and including the first separating one (at
// most 6) and then delivers its result.
// The result register holds one result; while the receiver stalls, loads
// without run_test are still taken, and a finished test waits in its last
// state until the register is free.
// Reset clears the sequencer and the result valid flag; the vector store is
// not cleared, so every slot must be loaded before the first test.
// ---------------------------------------------------------------------------
module obb_face_axis_overlap_test (
	input  logic          clk,
	input  logic          arst_n,
	obb_fat_in_if.sink    load,
	obb_fat_out_if.source result
);
	import obb_fat_pkg::*;

	state_t state_q, state_d;

	coord_t                   store_q [8][3];
	logic signed [DIFF_W-1:0] diff_q [3];

	logic [AXIS_WIDTH-1:0] axis_q;
	logic [2:0]            term_q;
	logic [1:0]            comp_q;
	logic                  drain_q;

	logic                  issue_en;
	logic                  out_load;
	logic                  last_issue;
	logic                  cmp_gt;
	logic                  sep_q;

	logic [SLOT_WIDTH-1:0]    term_slot;
	logic [SLOT_WIDTH-1:0]    axis_slot;
	logic signed [DIFF_W-1:0] mul_a;
	coord_t                   mul_b;
	logic signed [PROD_W-1:0] mul_p;

	logic signed [PROD_W-1:0] prod_s1;
	logic                     valid_s1;
	logic                     first_s1;
	logic                     last_s1;
	logic                     lhs_s1;
	logic                     first_term_s1;

	logic signed [DOT_W-1:0]  dot_q;
	logic signed [DOT_W-1:0]  dot_s2;
	logic                     valid_s2;
	logic                     lhs_s2;
	logic                     first_term_s2;

	logic                     dot_neg;
	logic [SUM_W-1:0]         dot_inv;
	logic [SUM_W-1:0]         rhs_base;
	logic [SUM_W-1:0]         lhs_q;
	logic [SUM_W-1:0]         rhs_q;

	logic                  out_valid_q;
	logic                  overlap_q;
	logic [AXIS_WIDTH-1:0] sep_axis_q;

	assign last_issue = (term_q == TERM_LAST) && (comp_q == COMP_LAST);
	assign cmp_gt     = lhs_q > rhs_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (load.valid && load.run_test) state_d = ST_PREP;
			end
			ST_PREP:  state_d = ST_ISSUE;
			ST_ISSUE: begin
				if (last_issue) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (drain_q) state_d = ST_CMP;
			end
			ST_CMP: begin
				if (cmp_gt || (axis_q == AXIS_LAST)) state_d = ST_DONE;
				else state_d = ST_ISSUE;
			end
			ST_DONE: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		load.ready = 1'b0;
		issue_en   = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_IDLE:  load.ready = 1'b1;
			ST_ISSUE: issue_en = 1'b1;
			ST_DONE:  out_load = !out_valid_q || result.ready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (load.valid && load.ready) begin
			store_q[load.vector_slot][0] <= load.coord_x;
			store_q[load.vector_slot][1] <= load.coord_y;
			store_q[load.vector_slot][2] <= load.coord_z;
		end
		if (state_q == ST_PREP) begin
			for (int k = 0; k < 3; k++) begin
				diff_q[k] <= DIFF_W'(store_q[SLOT_CENTER_B][k])
					- DIFF_W'(store_q[SLOT_CENTER_A][k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q  <= '0;
			term_q  <= TERM_DIFF;
			comp_q  <= COMP_FIRST;
			drain_q <= 1'b0;
			sep_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_PREP: begin
					axis_q  <= '0;
					term_q  <= TERM_DIFF;
					comp_q  <= COMP_FIRST;
				end
				ST_ISSUE: begin
					drain_q <= 1'b0;
					if (comp_q == COMP_LAST) begin
						comp_q <= COMP_FIRST;
						term_q <= term_q + 3'd1;
					end else begin
						comp_q <= comp_q + 2'd1;
					end
				end
				ST_DRAIN: drain_q <= 1'b1;
				ST_CMP: begin
					sep_q  <= cmp_gt;
					term_q <= TERM_DIFF;
					comp_q <= COMP_FIRST;
					if (!cmp_gt && (axis_q != AXIS_LAST)) axis_q <= axis_q + 3'd1;
				end
				default: begin
				end
			endcase
		end
	end

	assign term_slot = (term_q > TERM_LAST_A) ? term_q + 3'd1 : term_q;
	assign axis_slot = (axis_q > AXIS_LAST_A) ? axis_q + 3'd2 : axis_q + 3'd1;

	always_comb begin
		if (term_q == TERM_DIFF) mul_a = diff_q[comp_q];
		else mul_a = DIFF_W'(store_q[term_slot][comp_q]);
		mul_b = store_q[axis_slot][comp_q];
		mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= issue_en;
			valid_s2 <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1       <= mul_p;
		first_s1      <= comp_q == COMP_FIRST;
		last_s1       <= comp_q == COMP_LAST;
		lhs_s1        <= term_q == TERM_DIFF;
		first_term_s1 <= term_q == TERM_FIRST;
		if (valid_s1) begin
			if (first_s1) dot_q <= DOT_W'(prod_s1);
			else dot_q <= dot_q + DOT_W'(prod_s1);
		end
		dot_s2        <= dot_q + DOT_W'(prod_s1);
		lhs_s2        <= lhs_s1;
		first_term_s2 <= first_term_s1;
	end

	// The magnitude is formed as the inverted word plus the sign as carry in.
	assign dot_neg  = dot_s2[DOT_W-1];
	assign dot_inv  = SUM_W'(unsigned'(dot_neg ? ~dot_s2 : dot_s2));
	assign rhs_base = first_term_s2 ? '0 : rhs_q;

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			if (lhs_s2) lhs_q <= dot_inv + SUM_W'(dot_neg);
			else rhs_q <= rhs_base + dot_inv + SUM_W'(dot_neg);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			overlap_q  <= !sep_q;
			sep_axis_q <= sep_q ? axis_q : AXIS_NONE;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.overlap         = overlap_q;
	assign result.separating_axis = sep_axis_q;

endmodule

[src/obb_fat_checker.sv]
// ---------------------------------------------------------------------------
// obb_fat_checker
// Port-level checks of the overlap test, bound to the top level.
// ---------------------------------------------------------------------------
module obb_fat_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               load_valid,
	input logic                               load_ready,
	input logic                               load_run_test,
	input logic                               result_valid,
	input logic                               result_ready,
	input logic                               result_overlap,
	input logic [obb_fat_pkg::AXIS_WIDTH-1:0] result_separating_axis
);
	import obb_fat_pkg::*;

	// A stalled result keeps its value.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid
			&& $stable(result_overlap) && $stable(result_separating_axis))
		else $error("stalled result changed");

	// Overlap is reported exactly when no separating axis is named.
	a_overlap_axis: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_overlap == (result_separating_axis == AXIS_NONE)))
		else $error("overlap flag and separating axis disagree");

	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_separating_axis <= AXIS_NONE))
		else $error("separating axis out of range");

	// A test request makes the block busy in the next cycle.
	a_busy_after_test: assert property (@(posedge clk) disable iff (!arst_n)
		load_valid && load_ready && load_run_test |=> !load_ready)
		else $error("load taken while a test runs");

endmodule

bind obb_face_axis_overlap_test obb_fat_checker u_obb_fat_checker (
	.clk                    (clk),
	.arst_n                 (arst_n),
	.load_valid             (load.valid),
	.load_ready             (load.ready),
	.load_run_test          (load.run_test),
	.result_valid           (result.valid),
	.result_ready           (result.ready),
	.result_overlap         (result.overlap),
	.result_separating_axis (result.separating_axis)
);
